// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- hw/rtl/bmhq_pkg.sv -----
// ---------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the min priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int DATA_W = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef logic signed [DATA_W-1:0] data_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic  push;
    logic  pop;
    data_t value;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/bmhq_in_if.sv -----
// ---------------------------------------------------------------------------
// bmhq_in_if
// Command channel: push or pop request with its value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmhq_in_if;
  import bmhq_pkg::*;

  logic  valid;
  logic  ready;
  logic  command;
  data_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ----- hw/rtl/bmhq_out_if.sv -----
// ---------------------------------------------------------------------------
// bmhq_out_if
// Result channel: status, removed value, current minimum and count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmhq_out_if #(
  parameter int CNT_W = 7
);
  import bmhq_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  data_t            popped;
  data_t            minimum;
  logic [CNT_W-1:0] count;

  modport source (output valid, output ok, output popped, output minimum,
                  output count, input ready);
  modport sink   (input valid, input ok, input popped, input minimum,
                  input count, output ready);
endinterface

// ----- hw/rtl/binary_min_heap_queue_core.sv -----
// ---------------------------------------------------------------------------
// binary_min_heap_queue_core
// Bounded min priority queue on a sorted chain of cells, minimum in cell 0.
// ---------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid / ready      | command, value
//   out_ch   | out | valid / ready      | ok, popped, minimum, count
//
// One item per cycle while results are taken: all cells compare the pushed
// value in parallel and shift by one slot toward or away from cell 0, so the
// result is registered and shown in the cycle after acceptance.
// Reset clears the count and the output valid; cell contents are don't-care.
// A stalled result holds in the output register; in_ch.ready stays low
// until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_min_heap_queue_core #(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst_n,
  bmhq_in_if.sink    in_ch,
  bmhq_out_if.source out_ch
);
  import bmhq_pkg::*;

  localparam int               CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic             ok_r;
  data_t            popped_r, minimum_r;
  logic             ok_nxt;
  data_t            popped_nxt, minimum_nxt;

  cell_ctrl_t ctrl;
  data_t      cell_val   [CAPACITY];
  logic       cell_gt    [CAPACITY];
  data_t      left_val   [CAPACITY];
  logic       left_gt    [CAPACITY];
  data_t      right_val  [CAPACITY];

  logic fire, is_push, full, empty, push_ok, pop_ok;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.command == CMD_PUSH);
  assign full        = (count_r == CAP_C);
  assign empty       = (count_r == '0);
  assign push_ok     = fire && is_push && !full;
  assign pop_ok      = fire && !is_push && !empty;

  assign ctrl.push  = push_ok;
  assign ctrl.pop   = pop_ok;
  assign ctrl.value = in_ch.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_val[i] = '0;
      assign left_gt[i]  = 1'b0;
    end else begin : g_mid
      assign left_val[i] = cell_val[i-1];
      assign left_gt[i]  = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_val[i] = cell_val[i];
    end else begin : g_body
      assign right_val[i] = cell_val[i+1];
    end

    bmhq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cnt       (count_r),
      .left_val  (left_val[i]),
      .left_gt   (left_gt[i]),
      .right_val (right_val[i]),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    ok_nxt      = push_ok || pop_ok;
    popped_nxt  = pop_ok ? cell_val[0] : '0;
    minimum_nxt = empty ? '0 : cell_val[0];
    if (push_ok) begin
      count_nxt = count_r + ONE_C;
      if (empty || (in_ch.value < cell_val[0])) begin
        minimum_nxt = in_ch.value;
      end
    end else if (pop_ok) begin
      count_nxt   = count_r - ONE_C;
      minimum_nxt = (count_r > ONE_C) ? cell_val[1] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ok_r      <= ok_nxt;
      popped_r  <= popped_nxt;
      minimum_r <= minimum_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.ok      = ok_r;
  assign out_ch.popped  = popped_r;
  assign out_ch.minimum = minimum_r;
  assign out_ch.count   = count_r;

  // occupancy bound
  `ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > CAP_C)
  // accepted push into a non-full queue grows the count by one
  `ASSERT_CLK(a_push_count, clk, rst_n, push_ok |=> (count_r == $past(count_r) + ONE_C))
  // head of the chain stays sorted
  `ASSERT_NEVER(a_head_order, clk, rst_n, (count_r > ONE_C) && (cell_val[1] < cell_val[0]))
  // refused operation never reports a removed value
  `ASSERT_NEVER(a_refused_zero, clk, rst_n, out_valid_r && !ok_r && (popped_r != '0))

endmodule

// ----- hw/rtl/bmhq_cell.sv -----
// ---------------------------------------------------------------------------
// bmhq_cell
// One slot of the sorted cell chain; holds one value, shifts with neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  bmhq_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]     cnt,
  input  bmhq_pkg::data_t      left_val,
  input  logic                 left_gt,
  input  bmhq_pkg::data_t      right_val,
  output bmhq_pkg::data_t      val,
  output logic                 gt
);
  import bmhq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  data_t val_r;
  data_t val_nxt;

  // new value belongs here or further left: slot empty or value smaller
  assign gt  = (IDX_C >= cnt) || (ctrl.value < val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.push) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt) begin
        val_nxt = ctrl.value;
      end
    end else if (ctrl.pop) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- verif/binary_min_heap_queue_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_min_heap_queue_core_tb
// Self-checking bench for the min priority queue. Push and pop items go in
// through a random-gap driver. A heap kept in the bench predicts ok, popped
// value, minimum and count for each accepted item. A monitor checks each
// result against the oldest prediction while the sink stalls at random.
// ---------------------------------------------------------------------------

module binary_min_heap_queue_core_tb;
  import bmhq_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int CNT_W      = 7;
  localparam int RAND_ITEMS = 1800;
  localparam int PHASE_LEN  = 150;
  localparam int HOLD_AT    = 1200;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_AT   = 900;

  typedef struct {
    cmd_t  cmd;
    data_t value;
    bit    drain_first;  // wait for all results before offering this one
  } queue_op_t;

  typedef struct {
    logic             ok;
    data_t            popped;
    data_t            minimum;
    logic [CNT_W-1:0] count;
  } queue_res_t;

  logic clk = 1'b0;
  logic rst_n;

  bmhq_in_if                  in_ch ();
  bmhq_out_if #(.CNT_W(CNT_W)) out_ch ();

  binary_min_heap_queue_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  queue_op_t  op_queue[$];
  queue_res_t result_queue[$];
  data_t      heap_vals[CAPACITY];
  int         heap_size;
  int         total_items;
  int         accepted_cnt;
  int         err_cnt;
  queue_op_t  cur_op;
  bit         long_stall_done;
  int         stall_left;

  // idle percentage for the current phase of the run
  function automatic int idle_pct(input bit sink_side);
    case ((accepted_cnt / PHASE_LEN) % 4)
      1:       idle_pct = sink_side ? 0 : 53;
      2:       idle_pct = sink_side ? 53 : 0;
      3:       idle_pct = 37;
      default: idle_pct = 0;
    endcase
  endfunction

  // heap model: applies one item and returns the result it causes
  task automatic heap_apply(input cmd_t cmd, input data_t val, output queue_res_t r);
    int    pos;
    int    parent;
    int    lchild;
    int    rchild;
    int    best;
    bit    done;
    data_t tmp;
    r.ok     = 1'b0;
    r.popped = '0;
    if (cmd == CMD_PUSH) begin
      if (heap_size < CAPACITY) begin
        pos = heap_size;
        heap_vals[pos] = val;
        heap_size++;
        done = 1'b0;
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_vals[pos] < heap_vals[parent]) begin
            tmp = heap_vals[pos];
            heap_vals[pos] = heap_vals[parent];
            heap_vals[parent] = tmp;
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
        r.ok = 1'b1;
      end
    end else if (heap_size > 0) begin
      r.popped = heap_vals[0];
      heap_size--;
      heap_vals[0] = heap_vals[heap_size];
      pos = 0;
      done = 1'b0;
      while (!done) begin
        lchild = 2 * pos + 1;
        rchild = lchild + 1;
        best = pos;
        if (lchild < heap_size && heap_vals[lchild] < heap_vals[best]) best = lchild;
        if (rchild < heap_size && heap_vals[rchild] < heap_vals[best]) best = rchild;
        if (best == pos) begin
          done = 1'b1;
        end else begin
          tmp = heap_vals[pos];
          heap_vals[pos] = heap_vals[best];
          heap_vals[best] = tmp;
          pos = best;
        end
      end
      r.ok = 1'b1;
    end
    r.minimum = (heap_size > 0) ? heap_vals[0] : '0;
    r.count   = CNT_W'(heap_size);
  endtask

  task automatic add_op(input cmd_t cmd, input data_t val);
    queue_op_t op;
    op.cmd = cmd;
    op.value = val;
    op.drain_first = 1'b0;
    op_queue.push_back(op);
  endtask

  // mix of full-range, small-range (many duplicates) and extreme values
  function automatic data_t rand_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) begin
      rand_value = data_t'($urandom);
    end else if (sel < 8) begin
      rand_value = data_t'($signed($urandom_range(16)) - 8);
    end else begin
      case ($urandom_range(5))
        0:       rand_value = 32'sh7fffffff;
        1:       rand_value = 32'sh80000000;
        2:       rand_value = 32'sh7ffffffe;
        3:       rand_value = 32'sh80000001;
        4:       rand_value = -32'sd1;
        default: rand_value = '0;
      endcase
    end
  endfunction

  // driver: one item offered at a time, held until accepted
  always @(posedge clk) begin
    queue_res_t exp_res;
    bit         offering;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.command <= CMD_PUSH;
      in_ch.value   <= '0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        heap_apply(cur_op.cmd, cur_op.value, exp_res);
        result_queue.push_back(exp_res);
        accepted_cnt++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (op_queue.size() > 0 && !(op_queue[0].drain_first && result_queue.size() != 0)
            && $urandom_range(99) >= idle_pct(1'b0)) begin
          cur_op = op_queue.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.command <= cur_op.cmd;
          in_ch.value   <= cur_op.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_stall_done && accepted_cnt >= HOLD_AT) begin
      long_stall_done = 1'b1;
      stall_left = HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    queue_res_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_queue.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("ERROR: result with none pending: ok=%0b popped=%0d min=%0d count=%0d",
                   out_ch.ok, out_ch.popped, out_ch.minimum, out_ch.count);
      end else begin
        exp_res = result_queue.pop_front();
        if (out_ch.ok !== exp_res.ok || out_ch.popped !== exp_res.popped ||
            out_ch.minimum !== exp_res.minimum || out_ch.count !== exp_res.count) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: ok %0b/%0b popped %0d/%0d min %0d/%0d count %0d/%0d (exp/act)",
                     exp_res.ok, out_ch.ok, exp_res.popped, out_ch.popped,
                     exp_res.minimum, out_ch.minimum, exp_res.count, out_ch.count);
        end
      end
    end
  end

  initial begin
    int push_pct;
    int seg_len;
    int n_directed;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.command = CMD_PUSH;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    heap_size    = 0;
    accepted_cnt = 0;
    err_cnt      = 0;
    long_stall_done = 1'b0;

    // directed: empty pop, extremes, duplicates, drain past empty
    add_op(CMD_POP, 32'sh12345678);
    add_op(CMD_PUSH, 32'sh7fffffff);
    add_op(CMD_PUSH, 32'sh80000000);
    add_op(CMD_PUSH, '0);
    add_op(CMD_PUSH, -32'sd1);
    add_op(CMD_PUSH, 32'sd1);
    add_op(CMD_PUSH, 32'sd5);
    add_op(CMD_PUSH, 32'sd5);
    repeat (7) add_op(CMD_POP, '0);
    add_op(CMD_POP, -32'sd1);
    add_op(CMD_PUSH, -32'sd7);
    add_op(CMD_POP, 32'sh7fffffff);
    n_directed = op_queue.size();

    // random: fill runs hit the full queue, drain runs hit the empty one
    while (op_queue.size() < n_directed + RAND_ITEMS) begin
      case ($urandom_range(2))
        0:       begin push_pct = 90; seg_len = $urandom_range(80, 110); end
        1:       begin push_pct = 10; seg_len = $urandom_range(80, 110); end
        default: begin push_pct = 50; seg_len = $urandom_range(20, 60); end
      endcase
      repeat (seg_len) begin
        if ($urandom_range(99) < push_pct) add_op(CMD_PUSH, rand_value());
        else add_op(CMD_POP, data_t'($urandom));
      end
    end
    op_queue[DRAIN_AT].drain_first = 1'b1;
    total_items = op_queue.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_items || result_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && result_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
